// ----- design/set_assoc_cache_replacement_defines.svh -----
// Assertion helpers shared by the cache replacement design.
`ifndef SET_ASSOC_CACHE_REPLACEMENT_DEFINES_SVH
`define SET_ASSOC_CACHE_REPLACEMENT_DEFINES_SVH

// Implication checked in the same cycle.
`define SACR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SACR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sacr_pkg.sv -----
// ----------------------------------------------------------------------------
// sacr_pkg
// Types, sizes and helpers for the set-associative tag store.
// ----------------------------------------------------------------------------
package sacr_pkg;

    // Sets, ways, line bytes and predictor entries are powers of two.
    localparam int NUM_SETS     = 4;
    localparam int NUM_WAYS     = 2;
    localparam int LINE_BYTES   = 8;
    localparam int PRED_ENTRIES = 64;
    localparam int REGRET_DEPTH = 4;

    localparam int OFS_W  = $clog2(LINE_BYTES);
    localparam int SETB   = $clog2(NUM_SETS);
    localparam int SET_W  = (SETB > 0) ? SETB : 1;
    localparam int BLK_W  = 32 - OFS_W;
    localparam int TAG_W  = BLK_W - SETB;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int PRED_W = (PRED_ENTRIES > 1) ? $clog2(PRED_ENTRIES) : 1;
    localparam int RF_W   = $clog2(REGRET_DEPTH + 1);

    localparam logic [31:0] STAMP_MAX  = 32'hFFFF_FFFF;
    localparam logic [2:0]  PRED_INIT  = 3'd4;
    localparam logic [2:0]  PRED_MAX   = 3'd7;
    localparam logic [1:0]  RRPV_FILL  = 2'd2;
    localparam logic [1:0]  RRPV_TOP   = 2'd3;
    localparam logic [15:0] LFSR_SEED  = 16'h0001;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    typedef enum logic [2:0] {
        POL_LRU     = 3'd0,
        POL_FIFO    = 3'd1,
        POL_RANDOM  = 3'd2,
        POL_SRRIP   = 3'd3,
        POL_HAWKEYE = 3'd4,
        POL_DRP     = 3'd5
    } t_policy;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [31:0]       last_use;
        logic [31:0]       fill;
        logic [1:0]        rrpv;
        logic [PRED_W-1:0] pidx;
        logic              reused;
        logic              stable;
    } t_line;

    typedef t_line [NUM_WAYS-1:0] t_row;

    typedef struct packed {
        logic [31:0] access_pc;
        logic [31:0] access_address;
    } t_access;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [2:0]  way_used;
        logic [28:0] victim_block_address;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } t_result;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == STAMP_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ----- design/set_assoc_cache_replacement.sv -----
// The result strobe o_done is registered from the update step, which follows
// the lookup step after start is taken. A new access is taken only in idle, so
// one access at a time runs; the update step uses the registered predictor read.
// Reset is synchronous and active low: it clears all lines, counters and
// predictor valid bits at once, with no clearing pass.
`include "set_assoc_cache_replacement_defines.svh"
// ----------------------------------------------------------------------------
// set_assoc_cache_replacement
// Set-associative tag store with selectable replacement policy.
// ----------------------------------------------------------------------------
module set_assoc_cache_replacement
    import sacr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_access    i_access,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    output logic       o_done,
    output t_result    o_result
);

    t_cmd cmd;

    sacr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    sacr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_access    (i_access),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    `SACR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
    `SACR_ASSERT_NOW(a_done_latency, start && !busy, ##3 o_done, "result strobe late")
    `SACR_ASSERT_NOW(a_hit_no_evict, o_done && o_result.hit,
        !o_result.evicted && o_result.victim_block_address == 29'd0, "hit with eviction")
    `SACR_ASSERT_NOW(a_done_idle, o_done, !busy, "result while busy")

endmodule

// ----- design/sacr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sacr_ctrl
// Sequencer for one access: accept, lookup, update.
// ----------------------------------------------------------------------------
module sacr_ctrl
    import sacr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy         = 1'b0;
                o_cmd.accept = start;
            end
            ST_LOOKUP: o_cmd.lookup = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

// ----- design/sacr_dp.sv -----
// ----------------------------------------------------------------------------
// sacr_dp
// Tag store, replacement state, predictor memory and statistics.
// ----------------------------------------------------------------------------
module sacr_dp
    import sacr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_access     i_access,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    output logic        o_done,
    output t_result     o_result
);

    logic [2:0]        r_policy;
    t_row              r_rows [NUM_SETS];
    logic [31:0]       r_clk;
    logic [15:0]       r_lfsr, n_lfsr;
    logic [31:0]       r_hits, r_misses, r_evicts;
    logic [BLK_W-1:0]  r_regret [REGRET_DEPTH];
    logic [RF_W-1:0]   r_rfill;
    logic [2:0]        r_pmem [PRED_ENTRIES];
    logic [PRED_ENTRIES-1:0] r_pvld;

    // Access captured at accept.
    logic [31:0]       r_pc;
    logic [BLK_W-1:0]  r_blk;
    t_row              r_row;

    // Lookup decision.
    logic              r_hit, r_evict;
    logic [WAY_W-1:0]  r_way;
    logic [BLK_W-1:0]  r_victim;
    t_row              r_new_row;
    logic [PRED_W-1:0] r_vic_pidx;
    logic              r_vic_reused;
    logic [2:0]        r_prd_a, r_prd_b;
    logic              r_pva, r_pvb;

    t_policy           mode;
    logic [SET_W-1:0]  set_idx, cur_set;
    logic [TAG_W-1:0]  tag;
    logic [PRED_W-1:0] pc_idx;

    logic              hit, full, evict, seen;
    logic [WAY_W-1:0]  hit_way, empty_way, vic_way, way;
    logic [WAY_W-1:0]  lru_way, fifo_way, drp_way, srrip_way;
    logic              drp_un_f, drp_st_f;
    logic [WAY_W-1:0]  drp_un, drp_st;
    logic [1:0]        rmax;
    logic [BLK_W-1:0]  victim;
    t_row              new_row;

    logic              train;
    logic [2:0]        vic_val, trained, pc_val;
    t_row              fin_row;
    logic [31:0]       n_hits, n_misses, n_evicts;

    logic [BLK_W-1:0]  acc_blk;

    assign acc_blk = i_access.access_address[31:OFS_W];
    assign mode    = (r_policy > 3'(POL_DRP)) ? POL_LRU : t_policy'(r_policy);
    assign set_idx = SET_W'(r_blk % NUM_SETS);
    assign cur_set = SET_W'(acc_blk % NUM_SETS);
    assign tag     = TAG_W'(r_blk >> SETB);
    assign pc_idx  = PRED_W'(r_pc % PRED_ENTRIES);

    // ---------------- lookup ----------------
    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        full      = 1'b1;
        empty_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (r_row[w].valid && r_row[w].tag == tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!r_row[w].valid) begin
                full      = 1'b0;
                empty_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        lru_way  = '0;
        fifo_way = '0;
        srrip_way = '0;
        rmax     = r_row[0].rrpv;
        drp_un_f = 1'b0;
        drp_st_f = 1'b0;
        drp_un   = '0;
        drp_st   = '0;
        for (int w = 1; w < NUM_WAYS; w++) begin
            if (r_row[w].last_use < r_row[lru_way].last_use) lru_way = WAY_W'(w);
            if (r_row[w].fill < r_row[fifo_way].fill) fifo_way = WAY_W'(w);
            if (r_row[w].rrpv > rmax) begin
                rmax      = r_row[w].rrpv;
                srrip_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!r_row[w].stable) begin
                if (!drp_un_f || r_row[w].last_use < r_row[drp_un].last_use) begin
                    drp_un = WAY_W'(w);
                end
                drp_un_f = 1'b1;
            end else begin
                if (!drp_st_f || r_row[w].last_use < r_row[drp_st].last_use) begin
                    drp_st = WAY_W'(w);
                end
                drp_st_f = 1'b1;
            end
        end
        drp_way = drp_un_f ? drp_un : drp_st;
    end

    always_comb begin
        evict  = !hit && full;
        n_lfsr = r_lfsr;
        case (mode)
            POL_FIFO:   vic_way = fifo_way;
            POL_RANDOM: begin
                n_lfsr  = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
                vic_way = WAY_W'(n_lfsr % NUM_WAYS);
            end
            POL_SRRIP:  vic_way = srrip_way;
            POL_DRP:    vic_way = drp_way;
            default:    vic_way = lru_way;
        endcase
        way    = hit ? hit_way : (full ? vic_way : empty_way);
        victim = evict ? BLK_W'({r_row[vic_way].tag, set_idx} >> (SET_W - SETB)) : '0;
    end

    // The victim pushed by this access can never match the filling block, so only
    // the entry that the push drops is left out.
    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < REGRET_DEPTH; j++) begin
            if (RF_W'(j) < r_rfill && r_regret[j] == r_blk &&
                !(j == 0 && r_rfill == RF_W'(REGRET_DEPTH) && evict)) begin
                seen = 1'b1;
            end
        end
    end

    always_comb begin
        new_row = r_row;
        if (hit) begin
            if (mode == POL_LRU || mode == POL_HAWKEYE || mode == POL_DRP) begin
                new_row[way].last_use = r_clk;
            end
            if (mode == POL_SRRIP) new_row[way].rrpv = 2'd0;
            if (mode == POL_HAWKEYE) new_row[way].reused = 1'b1;
        end else begin
            if (evict && mode == POL_SRRIP) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    new_row[w].rrpv = r_row[w].rrpv + (RRPV_TOP - rmax);
                end
            end
            new_row[way].valid    = 1'b1;
            new_row[way].tag      = tag;
            new_row[way].fill     = r_clk;
            new_row[way].last_use = r_clk;
            case (mode)
                POL_SRRIP: new_row[way].rrpv = RRPV_FILL;
                POL_HAWKEYE: begin
                    new_row[way].pidx   = pc_idx;
                    new_row[way].reused = 1'b0;
                end
                POL_DRP: new_row[way].stable = seen;
                default: new_row[way].stable = r_row[way].stable;
            endcase
        end
    end

    // ---------------- update ----------------
    always_comb begin
        train   = r_evict && mode == POL_HAWKEYE;
        vic_val = r_pvb ? r_prd_b : PRED_INIT;
        if (r_vic_reused) begin
            trained = (vic_val < PRED_MAX) ? vic_val + 3'd1 : vic_val;
        end else begin
            trained = (vic_val > 3'd0) ? vic_val - 3'd1 : vic_val;
        end
        pc_val  = (train && pc_idx == r_vic_pidx) ? trained : (r_pva ? r_prd_a : PRED_INIT);
        fin_row = r_new_row;
        if (mode == POL_HAWKEYE && !r_hit && pc_val < PRED_INIT) begin
            fin_row[r_way].last_use = '0;
        end
        n_hits   = r_hit ? sat_inc(r_hits) : r_hits;
        n_misses = r_hit ? r_misses : sat_inc(r_misses);
        n_evicts = r_evict ? sat_inc(r_evicts) : r_evicts;
    end

    // Line state is small and fully reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    r_rows[s][w]      <= '0;
                    r_rows[s][w].rrpv <= RRPV_FILL;
                end
            end
        end else if (i_cmd.update) begin
            r_rows[set_idx] <= fin_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 3'(POL_LRU);
            r_clk    <= '0;
            r_lfsr   <= LFSR_SEED;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
            r_rfill  <= '0;
            r_pvld   <= '0;
            o_done   <= 1'b0;
        end else begin
            o_done <= i_cmd.update;
            if (i_cfg_we) r_policy <= i_cfg_wdata;
            if (i_cmd.accept) r_clk <= sat_inc(r_clk);
            // The generator steps only when a random victim is actually drawn.
            if (i_cmd.lookup && evict) r_lfsr <= n_lfsr;
            if (i_cmd.update) begin
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
                if (r_evict && mode == POL_DRP && r_rfill < RF_W'(REGRET_DEPTH)) begin
                    r_rfill <= r_rfill + RF_W'(1);
                end
                if (train) r_pvld[r_vic_pidx] <= 1'b1;
            end
        end
    end

    // Regret buffer holds undefined data until written; the fill count guards it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && r_evict && mode == POL_DRP) begin
            for (int j = 0; j < REGRET_DEPTH; j++) begin
                if (r_rfill == RF_W'(REGRET_DEPTH)) begin
                    if (j == REGRET_DEPTH - 1) r_regret[j] <= r_victim;
                    else r_regret[j] <= r_regret[j+1];
                end else if (RF_W'(j) == r_rfill) begin
                    r_regret[j] <= r_victim;
                end
            end
        end
    end

    // Predictor memory: two registered reads in lookup, one write in update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_prd_a <= r_pmem[pc_idx];
            r_prd_b <= r_pmem[r_row[vic_way].pidx];
        end
        if (i_cmd.update && train) begin
            r_pmem[r_vic_pidx] <= trained;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pc  <= i_access.access_pc;
            r_blk <= acc_blk;
            r_row <= r_rows[cur_set];
        end
        if (i_cmd.lookup) begin
            r_hit         <= hit;
            r_evict       <= evict;
            r_way         <= way;
            r_victim      <= victim;
            r_new_row     <= new_row;
            r_vic_pidx    <= r_row[vic_way].pidx;
            r_vic_reused  <= r_row[vic_way].reused;
            r_pva         <= r_pvld[pc_idx];
            r_pvb         <= r_pvld[r_row[vic_way].pidx];
        end
        if (i_cmd.update) begin
            o_result.hit                  <= r_hit;
            o_result.evicted              <= r_evict;
            o_result.way_used             <= 3'(r_way);
            o_result.victim_block_address <= 29'(r_victim);
            o_result.hit_total            <= n_hits;
            o_result.miss_total           <= n_misses;
            o_result.eviction_total       <= n_evicts;
        end
    end

endmodule

// ----- bench/cache_checker.sv -----
// ----------------------------------------------------------------------------
// cache_checker
// Watches accepted accesses and result strobes of the tag store, predicts
// each result from its own model of the lines and policies, and counts
// every mismatch.
// ----------------------------------------------------------------------------
module cache_checker
    import sacr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_access i_access,
    input  logic    i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending
);

    localparam int LINES = NUM_SETS * NUM_WAYS;
    localparam int EXP_DEPTH = 16;

    logic [2:0]  mode_q;
    logic        vld [LINES];
    logic [26:0] tagm [LINES];
    logic [31:0] used_at [LINES];
    logic [31:0] filled_at [LINES];
    logic [1:0]  rrpv [LINES];
    logic [5:0]  pidx [LINES];
    logic        reused [LINES];
    logic        stable [LINES];
    logic [31:0] clk_cnt;
    logic [2:0]  pred [PRED_ENTRIES];
    logic [28:0] regret [REGRET_DEPTH];
    int          regret_n;
    logic [15:0] lfsr;
    logic [31:0] hits, misses, evicts;
    t_result     exp_mem [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;

    assign o_pending = exp_wr - exp_rd;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic predict_access(input t_access a);
        logic [28:0] blk;
        int set, base, way, l, m, un, st, p;
        logic [26:0] tg;
        logic hit_f, found, seen;
        t_policy pol;
        t_result r;
        blk  = a.access_address[31:3];
        set  = int'(blk % NUM_SETS);
        tg   = 27'(blk / NUM_SETS);
        base = set * NUM_WAYS;
        pol  = (mode_q > 5) ? POL_LRU : t_policy'(mode_q);
        r = '0;
        hit_f = 1'b0;
        way = 0;
        clk_cnt = bump(clk_cnt);
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (vld[base+w] && tagm[base+w] == tg) begin
                hit_f = 1'b1;
                way = w;
            end
        if (hit_f) begin
            l = base + way;
            hits = bump(hits);
            if (pol inside {POL_LRU, POL_HAWKEYE, POL_DRP}) used_at[l] = clk_cnt;
            if (pol == POL_SRRIP) rrpv[l] = 2'd0;
            if (pol == POL_HAWKEYE) reused[l] = 1'b1;
        end else begin
            misses = bump(misses);
            found = 1'b0;
            for (int w = NUM_WAYS - 1; w >= 0; w--)
                if (!vld[base+w]) begin
                    found = 1'b1;
                    way = w;
                end
            if (!found) begin
                r.evicted = 1'b1;
                evicts = bump(evicts);
                way = 0;
                case (pol)
                    POL_FIFO: begin
                        for (int w = 1; w < NUM_WAYS; w++)
                            if (filled_at[base+w] < filled_at[base+way]) way = w;
                    end
                    POL_RANDOM: begin
                        lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
                        way = int'(lfsr % NUM_WAYS);
                    end
                    POL_SRRIP: begin
                        m = 0;
                        for (int w = 0; w < NUM_WAYS; w++)
                            if (rrpv[base+w] > m) begin
                                m = rrpv[base+w];
                                way = w;
                            end
                        for (int w = 0; w < NUM_WAYS; w++)
                            rrpv[base+w] = rrpv[base+w] + 2'(3 - m);
                    end
                    POL_DRP: begin
                        un = -1;
                        st = -1;
                        for (int w = 0; w < NUM_WAYS; w++)
                            if (!stable[base+w]) begin
                                if (un < 0 || used_at[base+w] < used_at[base+un]) un = w;
                            end else if (st < 0 || used_at[base+w] < used_at[base+st]) begin
                                st = w;
                            end
                        way = (un >= 0) ? un : st;
                    end
                    default: begin
                        for (int w = 1; w < NUM_WAYS; w++)
                            if (used_at[base+w] < used_at[base+way]) way = w;
                    end
                endcase
                l = base + way;
                r.victim_block_address = 29'(tagm[l] * NUM_SETS + set);
                if (pol == POL_DRP) begin
                    if (regret_n < REGRET_DEPTH) begin
                        regret[regret_n] = r.victim_block_address;
                        regret_n++;
                    end else begin
                        for (int i = 0; i < REGRET_DEPTH - 1; i++) regret[i] = regret[i+1];
                        regret[REGRET_DEPTH-1] = r.victim_block_address;
                    end
                end
                if (pol == POL_HAWKEYE) begin
                    p = pidx[l];
                    if (reused[l]) begin
                        if (pred[p] < 7) pred[p]++;
                    end else if (pred[p] > 0) begin
                        pred[p]--;
                    end
                end
            end
            l = base + way;
            vld[l] = 1'b1;
            tagm[l] = tg;
            filled_at[l] = clk_cnt;
            used_at[l] = clk_cnt;
            if (pol == POL_SRRIP) begin
                rrpv[l] = 2'd2;
            end else if (pol == POL_HAWKEYE) begin
                p = int'(a.access_pc % PRED_ENTRIES);
                pidx[l] = 6'(p);
                reused[l] = 1'b0;
                if (pred[p] < 4) used_at[l] = '0;
            end else if (pol == POL_DRP) begin
                seen = 1'b0;
                for (int i = 0; i < regret_n; i++)
                    if (regret[i] == blk) seen = 1'b1;
                stable[l] = seen;
            end
        end
        r.hit = hit_f;
        r.way_used = 3'(way);
        r.hit_total = hits;
        r.miss_total = misses;
        r.eviction_total = evicts;
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            mode_q = POL_LRU;
            for (int i = 0; i < LINES; i++) begin
                vld[i] = 1'b0; tagm[i] = '0; used_at[i] = '0; filled_at[i] = '0;
                rrpv[i] = 2'd2; pidx[i] = '0; reused[i] = 1'b0; stable[i] = 1'b0;
            end
            for (int i = 0; i < PRED_ENTRIES; i++) pred[i] = 3'd4;
            clk_cnt = '0; regret_n = 0; lfsr = 16'h0001;
            hits = '0; misses = '0; evicts = '0;
            o_errors = 0;
            exp_wr = 0;
            exp_rd = 0;
        end else begin
            if (i_done) begin
                if (exp_wr == exp_rd) begin
                    o_errors++;
                    if (o_errors <= 10) $display("Unexpected result %p", i_result);
                end else begin
                    e = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_result !== e) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("Mismatch: expected %p got %p", e, i_result);
                    end
                end
            end
            if (i_start && !i_busy) predict_access(i_access);
            if (i_cfg_we) mode_q = i_cfg_wdata;
        end
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives directed and random accesses through every replacement policy,
// with bursty issue and idle phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import sacr_pkg::*;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       start = 0;
    logic       busy;
    t_access    i_access = '0;
    logic       i_cfg_we = 0;
    logic [2:0] i_cfg_wdata = '0;
    logic       o_done;
    t_result    o_result;
    int         errors, pending;
    int         cycles = 0;

    always #2 i_clk = ~i_clk;

    set_assoc_cache_replacement i_dut (.*);

    cache_checker i_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_access,
        .i_cfg_we, .i_cfg_wdata, .i_done(o_done), .i_result(o_result),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Holds start until a transaction is taken, then drops it.
    task automatic issue(input logic [31:0] pc, input logic [31:0] addr);
        @(negedge i_clk);
        start = 1;
        i_access = '{access_pc: pc, access_address: addr};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_policy(input logic [2:0] m);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_wdata = m;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Addresses in a narrow window so that sets fill and evict often.
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom();
        case ($urandom_range(0, 9))
            0: return a;
            1: return {a[31:8] | 24'hFF_FFF0, a[7:0]};
            default: return a & 32'h0000_00FF;
        endcase
    endfunction

    initial begin
        logic [2:0] modes[8];
        modes = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        // Directed: address and pc extremes, fill both ways, evict.
        issue(32'h0, 32'h0);
        issue(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(32'h0, 32'h0000_0020);
        issue(32'h3F, 32'h0000_0040);
        issue(32'h0, 32'h0000_0004);
        issue(32'hFFFF_FFFF, 32'hFFFF_FFE0);
        issue(32'h1, 32'h8000_0000);
        drain();
        foreach (modes[i]) begin
            set_policy(modes[i]);
            for (int n = 0; n < 100; n++) begin
                if (n == 50) drain();
                issue($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3),
                      pick_addr());
            end
        end
        set_policy(3'd4);
        for (int n = 0; n < 50; n++) issue($urandom(), pick_addr());
        set_policy(3'd0);
        drain();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
